// File: design/i2r_pkg.sv
// Shared constants, control word type and microprogram for the Roman numeral encoder.
`default_nettype none

package i2r_pkg;

	localparam int unsigned VALUE_W  = 12;
	localparam int unsigned SYM_W    = 8;
	localparam int unsigned WEIGHT_W = 10;
	localparam int unsigned PC_W     = 4;

	localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

	// Microprogram entry points and last step
	localparam logic [PC_W-1:0] START_PC = 4'd0;
	localparam logic [PC_W-1:0] LAST_PC  = 4'd12;
	localparam logic [PC_W-1:0] ERR_PC   = 4'd13;

	// Control word operations
	localparam logic [1:0] OP_TERM = 2'd0;
	localparam logic [1:0] OP_ERR  = 2'd1;

	localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;

	typedef struct packed {
		logic [1:0]          op;
		logic [WEIGHT_W-1:0] weight;
		logic [SYM_W-1:0]    ch1;
		logic [SYM_W-1:0]    ch2;
	} ucw_t;

	// Microprogram: one greedy term per step; a step repeats while its weight fits
	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t w;
		w = '{op: OP_ERR, weight: '0, ch1: SYM_NONE, ch2: SYM_NONE};
		case (pc)
			4'd0:  w = '{op: OP_TERM, weight: 10'd1000, ch1: "M", ch2: SYM_NONE};
			4'd1:  w = '{op: OP_TERM, weight: 10'd900,  ch1: "C", ch2: "M"};
			4'd2:  w = '{op: OP_TERM, weight: 10'd500,  ch1: "D", ch2: SYM_NONE};
			4'd3:  w = '{op: OP_TERM, weight: 10'd400,  ch1: "C", ch2: "D"};
			4'd4:  w = '{op: OP_TERM, weight: 10'd100,  ch1: "C", ch2: SYM_NONE};
			4'd5:  w = '{op: OP_TERM, weight: 10'd90,   ch1: "X", ch2: "C"};
			4'd6:  w = '{op: OP_TERM, weight: 10'd50,   ch1: "L", ch2: SYM_NONE};
			4'd7:  w = '{op: OP_TERM, weight: 10'd40,   ch1: "X", ch2: "L"};
			4'd8:  w = '{op: OP_TERM, weight: 10'd10,   ch1: "X", ch2: SYM_NONE};
			4'd9:  w = '{op: OP_TERM, weight: 10'd9,    ch1: "I", ch2: "X"};
			4'd10: w = '{op: OP_TERM, weight: 10'd5,    ch1: "V", ch2: SYM_NONE};
			4'd11: w = '{op: OP_TERM, weight: 10'd4,    ch1: "I", ch2: "V"};
			4'd12: w = '{op: OP_TERM, weight: 10'd1,    ch1: "I", ch2: SYM_NONE};
			default: w = '{op: OP_ERR, weight: '0, ch1: SYM_NONE, ch2: SYM_NONE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: design/integer_to_roman_encoder.sv
// Top level: microcoded Roman numeral encoder with a registered output stage.
// The first character is registered once the program steps whose weight does not fit are skipped.
// Each request walks the program, emitting a character for each step that fits, plus a step for
// the second character of a two-character term; a new request is stalled until the last one ends.
// Out-of-range requests give a single flagged result.
// Reset (arst_n low) clears the sequencer and output valid; payload is not reset.
`default_nettype none

module integer_to_roman_encoder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [i2r_pkg::VALUE_W-1:0]  value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [i2r_pkg::SYM_W-1:0]         symbol,
	output logic                              last,
	output logic                              out_of_range
);

	logic                          busy_q;
	logic                          sec_q;
	logic [i2r_pkg::PC_W-1:0]      pc_q;
	logic [i2r_pkg::VALUE_W-1:0]   rest_q;
	logic [i2r_pkg::SYM_W-1:0]     sec_ch_q;
	logic                          out_valid_q;
	logic [i2r_pkg::SYM_W-1:0]     sym_q;
	logic                          last_q;
	logic                          oor_q;

	i2r_pkg::ucw_t                 uw;
	logic [i2r_pkg::VALUE_W-1:0]   weight_x;
	logic [i2r_pkg::VALUE_W-1:0]   diff;
	logic                          fits;
	logic                          in_acc;
	logic                          in_bad;
	logic                          adv;
	logic                          emit;
	logic [i2r_pkg::SYM_W-1:0]     e_sym;
	logic                          e_last;
	logic                          e_oor;
	logic                          done;

	// Decode the current control word and test the term against the remainder
	assign uw       = i2r_pkg::ucode(pc_q);
	assign weight_x = {{(i2r_pkg::VALUE_W-i2r_pkg::WEIGHT_W){1'b0}}, uw.weight};
	assign fits     = rest_q >= weight_x;
	assign diff     = rest_q - weight_x;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign in_bad   = (value == '0) || (value > i2r_pkg::MAX_VALUE);
	assign adv      = busy_q && (!out_valid_q || !out_stall);

	// Select what this step emits
	always_comb begin
		emit   = 1'b0;
		e_sym  = i2r_pkg::SYM_NONE;
		e_last = 1'b0;
		e_oor  = 1'b0;
		done   = 1'b0;
		if (adv) begin
			if (sec_q) begin
				emit   = 1'b1;
				e_sym  = sec_ch_q;
				e_last = (rest_q == '0);
				done   = (rest_q == '0);
			end else begin
				case (uw.op)
					i2r_pkg::OP_TERM: begin
						if (fits) begin
							emit   = 1'b1;
							e_sym  = uw.ch1;
							e_last = (uw.ch2 == i2r_pkg::SYM_NONE) && (diff == '0);
							done   = e_last;
						end
					end
					default: begin
						emit   = 1'b1;
						e_oor  = 1'b1;
						e_last = 1'b1;
						done   = 1'b1;
					end
				endcase
			end
		end
	end

	// Advance the sequencer: repeat a step while it fits, else jump to the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sec_q       <= 1'b0;
			pc_q        <= i2r_pkg::START_PC;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				busy_q <= 1'b1;
				sec_q  <= 1'b0;
				pc_q   <= in_bad ? i2r_pkg::ERR_PC : i2r_pkg::START_PC;
			end else if (adv) begin
				if (done) begin
					busy_q <= 1'b0;
				end
				if (sec_q) begin
					sec_q <= 1'b0;
				end else if (uw.op == i2r_pkg::OP_TERM) begin
					if (fits) begin
						sec_q <= (uw.ch2 != i2r_pkg::SYM_NONE);
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
			end
		end
	end

	// Hold remainder, pending second character and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rest_q <= value;
		end else if (adv && !sec_q && uw.op == i2r_pkg::OP_TERM && fits) begin
			rest_q   <= diff;
			sec_ch_q <= uw.ch2;
		end
		if (emit) begin
			sym_q  <= e_sym;
			last_q <= e_last;
			oor_q  <= e_oor;
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol       = sym_q;
	assign last         = last_q;
	assign out_of_range = oor_q;

`ifndef ASSERT_OFF
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && oor_q |-> last_q && (sym_q == i2r_pkg::SYM_NONE))
		else $error("error result must be a single zero symbol");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> busy_q)
		else $error("accepted request did not start the sequencer");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !sec_q)
		else $error("second character pending while idle");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !sec_q |-> (pc_q <= i2r_pkg::LAST_PC) || (pc_q == i2r_pkg::ERR_PC))
		else $error("step counter left the program");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Testbench for integer_to_roman_encoder: directed and random requests against a greedy encoder.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROMAN_TERMS = 13;
	localparam int IDLE_PCT = 17;
	localparam int SETTLE_CYCLES = 40;

	typedef logic [i2r_pkg::VALUE_W-1:0] value_t;
	typedef logic [i2r_pkg::SYM_W-1:0]   glyph_t;

	typedef struct packed {
		glyph_t symbol;
		logic   last;
		logic   out_of_range;
	} roman_char_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	value_t              value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	glyph_t              symbol;
	logic                last;
	logic                out_of_range;

	roman_char_t pending_chars[$];
	int          mismatches = 0;
	bit          calm = 1'b0;

	integer_to_roman_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol       (symbol),
		.last         (last),
		.out_of_range (out_of_range)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Print one mismatch and count it
	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Look up one greedy term: its weight and its one or two characters
	function automatic void greedy_term(input int idx, output int weight,
			output glyph_t glyph1, output glyph_t glyph2);
		glyph2 = i2r_pkg::SYM_NONE;
		case (idx)
			0: begin weight = 1000; glyph1 = "M"; end
			1: begin weight = 900;  glyph1 = "C"; glyph2 = "M"; end
			2: begin weight = 500;  glyph1 = "D"; end
			3: begin weight = 400;  glyph1 = "C"; glyph2 = "D"; end
			4: begin weight = 100;  glyph1 = "C"; end
			5: begin weight = 90;   glyph1 = "X"; glyph2 = "C"; end
			6: begin weight = 50;   glyph1 = "L"; end
			7: begin weight = 40;   glyph1 = "X"; glyph2 = "L"; end
			8: begin weight = 10;   glyph1 = "X"; end
			9: begin weight = 9;    glyph1 = "I"; glyph2 = "X"; end
			10: begin weight = 5;   glyph1 = "V"; end
			11: begin weight = 4;   glyph1 = "I"; glyph2 = "V"; end
			default: begin weight = 1; glyph1 = "I"; end
		endcase
	endfunction

	// Queue the characters expected for one request, most significant first
	function automatic void encode_roman(input value_t v);
		int rest;
		int weight;
		glyph_t g1;
		glyph_t g2;
		glyph_t glyphs[$];
		roman_char_t ch;
		if (v == '0 || v > i2r_pkg::MAX_VALUE) begin
			ch = '{symbol: i2r_pkg::SYM_NONE, last: 1'b1, out_of_range: 1'b1};
			pending_chars.push_back(ch);
			return;
		end
		rest = int'(v);
		for (int t = 0; t < ROMAN_TERMS; t++) begin
			greedy_term(t, weight, g1, g2);
			while (rest >= weight) begin
				rest -= weight;
				glyphs.push_back(g1);
				if (g2 != i2r_pkg::SYM_NONE)
					glyphs.push_back(g2);
			end
		end
		foreach (glyphs[k]) begin
			ch = '{symbol: glyphs[k], last: (k == glyphs.size() - 1), out_of_range: 1'b0};
			pending_chars.push_back(ch);
		end
	endfunction

	// Present one request, idling at random first; hold it until taken
	task automatic send_value(input value_t v);
		bit taken;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (!in_stall) begin
				taken = 1'b1;
				encode_roman(v);
			end
			@(posedge clk);
		end
	endtask

	// Drop the request and wait until every expected character has come
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_chars.size() != 0);
	endtask

	// Pick a value: mostly valid numerals, many short, a few out of range
	function automatic value_t random_value();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return $urandom_range(1) ? '0 : value_t'($urandom_range(4095, 4000));
		else if (r < 30)
			return value_t'($urandom_range(49, 1));
		return value_t'($urandom_range(3999, 1));
	endfunction

	// Stall the output side at random
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

	// Check each accepted character against the oldest expectation
	initial begin : result_check
		roman_char_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character %02h", symbol));
				end else begin
					want = pending_chars.pop_front();
					if (symbol !== want.symbol)
						report_mismatch($sformatf("symbol %02h, want %02h",
							symbol, want.symbol));
					if (last !== want.last)
						report_mismatch($sformatf("last %b, want %b", last, want.last));
					if (out_of_range !== want.out_of_range)
						report_mismatch($sformatf("out_of_range %b, want %b",
							out_of_range, want.out_of_range));
				end
			end
		end
	end

	// Zero, the range edges, every term alone, the longest numeral, all-ones and alternating bit patterns
	task automatic test_corner_values();
		value_t corners[$] = '{12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd9, 12'd10,
			12'd40, 12'd50, 12'd90, 12'd100, 12'd400, 12'd500, 12'd900, 12'd1000,
			12'd1994, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2730, 12'd1365};
		foreach (corners[i])
			send_value(corners[i]);
	endtask

	// Send long numerals, then hold off until all of them are out
	task automatic test_pause_until_drained();
		send_value(12'd3888);
		send_value(12'd2888);
		send_value(12'd4000);
		send_value(12'd1888);
		wait_for_drain();
		send_value(12'd3777);
	endtask

	// Random requests with random idling on both sides
	task automatic test_random_values(input int count);
		for (int i = 0; i < count; i++)
			send_value(random_value());
	endtask

	// Random requests with no idling on either side
	task automatic test_back_to_back(input int count);
		calm = 1'b1;
		for (int i = 0; i < count; i++)
			send_value(random_value());
		calm = 1'b0;
	endtask

	// Reset, run the tests in turn, then settle and report
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_values();
		test_pause_until_drained();
		test_random_values(150);
		test_back_to_back(60);
		test_random_values(80);
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// End a run that hangs
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
